[rtl/tpdp_pkg.sv]
package tpdp_pkg;

    // Lane count is fixed by the eight activation ports
    localparam int LANES    = 8;
    localparam int CODE_W   = 2;
    localparam int WCODES_W = LANES * CODE_W;
    localparam int VL_W     = 4;
    localparam int SUM_W    = 32;
    localparam int GAMMA_W  = 16;
    localparam int PROD_W   = SUM_W + GAMMA_W;

    // Ternary weight codes; the two remaining codes mean zero
    localparam logic [CODE_W-1:0] WCODE_POS = 2'b01;
    localparam logic [CODE_W-1:0] WCODE_NEG = 2'b11;

    // Gamma after reset is 1.0 in Q4.12
    localparam logic signed [GAMMA_W-1:0] GAMMA_RESET = 16'sd4096;

    // Saturation limits of the accumulator and of the result
    localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fff_ffff;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

    // One result word
    typedef struct packed {
        logic signed [SUM_W-1:0] dot_result;
        logic                    saturated;
    } t_result;

endpackage

[rtl/tpdp_fifo.sv]
module tpdp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_wdata,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_rdata,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

[rtl/tpdp_front.sv]
module tpdp_front #(
    parameter int ACT_WIDTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_push,
    input  logic [tpdp_pkg::WCODES_W-1:0]               i_weight_codes,
    input  logic signed [ACT_WIDTH-1:0]                 i_acts [tpdp_pkg::LANES],
    input  logic [tpdp_pkg::VL_W-1:0]                   i_valid_lanes,
    input  logic                                        i_last,
    output logic                                        o_valid,
    output logic signed [ACT_WIDTH+$clog2(tpdp_pkg::LANES):0] o_lane_sum,
    output logic                                        o_last
);

    localparam int LN_W = ACT_WIDTH + 1;
    localparam int LS_W = ACT_WIDTH + 1 + $clog2(tpdp_pkg::LANES);

    logic signed [LN_W-1:0] n_lane [tpdp_pkg::LANES];
    logic signed [LN_W-1:0] r_lane [tpdp_pkg::LANES];
    logic                   r_valid;
    logic                   r_last;
    logic signed [LS_W-1:0] lane_sum;

    // Decode weights: mask zero lanes and lanes past the count, negate minus-one lanes
    always_comb begin
        logic [tpdp_pkg::CODE_W-1:0] code;
        logic                        lane_en;
        for (int i = 0; i < tpdp_pkg::LANES; i++) begin
            code    = i_weight_codes[tpdp_pkg::CODE_W*(tpdp_pkg::LANES-1-i) +: tpdp_pkg::CODE_W];
            lane_en = (i_valid_lanes > tpdp_pkg::VL_W'(i));
            n_lane[i] = '0;
            if (lane_en) begin
                case (code)
                    tpdp_pkg::WCODE_POS: n_lane[i] = LN_W'(i_acts[i]);
                    tpdp_pkg::WCODE_NEG: n_lane[i] = -LN_W'(i_acts[i]);
                    default:             n_lane[i] = '0;
                endcase
            end
        end
    end

    // Register the decoded lanes and their valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_lane <= n_lane;
            r_last <= i_last;
        end
    end

    // Add the lanes into one partial sum
    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < tpdp_pkg::LANES; i++) begin
            lane_sum = lane_sum + LS_W'(r_lane[i]);
        end
    end

    assign o_valid    = r_valid;
    assign o_lane_sum = lane_sum;
    assign o_last     = r_last;

endmodule

[rtl/tpdp_back.sv]
module tpdp_back #(
    parameter int LS_W       = 20,
    parameter int GAMMA_FRAC = 12,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_empty,
    input  logic signed [LS_W-1:0]                 i_lane_sum,
    input  logic                                   i_last,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]         i_out_count,
    input  logic signed [tpdp_pkg::GAMMA_W-1:0]    i_gamma,
    output logic                                   o_pop,
    output logic                                   o_res_valid,
    output tpdp_pkg::t_result                      o_res
);

    localparam int SW    = tpdp_pkg::SUM_W;
    localparam int AW    = ((LS_W > SW) ? LS_W : SW) + 1;
    localparam int PW    = tpdp_pkg::PROD_W;
    localparam int XW    = PW + 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic signed [XW-1:0] RND = XW'((XW'(1) << GAMMA_FRAC) >> 1);

    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] r_mul_in;
    logic signed [PW-1:0] r_prod;
    logic                 r_b_valid;
    logic                 r_c_valid;

    logic [CNT_W:0]       in_flight;
    logic                 room;
    logic                 take;
    logic signed [AW-1:0] acc;
    logic signed [SW-1:0] acc_sat;
    logic signed [XW-1:0] rounded;
    logic signed [XW-1:0] shifted;
    logic                 res_fits;

    // Issue a last word only when the output queue has a slot for it
    assign in_flight = (CNT_W+1)'(i_out_count) + (CNT_W+1)'(r_b_valid)
                     + (CNT_W+1)'(r_c_valid);
    assign room      = (in_flight < (CNT_W+1)'(OUT_DEPTH));
    assign take      = !i_q_empty && (!i_last || room);
    assign o_pop     = take;

    // Accumulate with saturation at the 32-bit limits
    always_comb begin
        acc = AW'(r_sum) + AW'(i_lane_sum);
        if ((acc[AW-1:SW-1] == '0) || (acc[AW-1:SW-1] == '1)) begin
            acc_sat = acc[SW-1:0];
        end else if (acc[AW-1]) begin
            acc_sat = tpdp_pkg::SUM_MIN;
        end else begin
            acc_sat = tpdp_pkg::SUM_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (take) begin
                r_sum <= i_last ? '0 : acc_sat;
            end
            r_b_valid <= take && i_last;
            r_c_valid <= r_b_valid;
        end
    end

    // Drop the finished sum into the multiplier, then scale by gamma
    always_ff @(posedge i_clk) begin
        if (take && i_last) begin
            r_mul_in <= acc_sat;
        end
        if (r_b_valid) begin
            r_prod <= r_mul_in * i_gamma;
        end
    end

    // Round, shift down and clip the scaled product
    always_comb begin
        rounded  = XW'(r_prod) + RND;
        shifted  = rounded >>> GAMMA_FRAC;
        res_fits = (shifted[XW-1:SW-1] == '0) || (shifted[XW-1:SW-1] == '1);
        o_res.saturated = !res_fits;
        if (res_fits) begin
            o_res.dot_result = shifted[SW-1:0];
        end else if (shifted[XW-1]) begin
            o_res.dot_result = tpdp_pkg::SUM_MIN;
        end else begin
            o_res.dot_result = tpdp_pkg::SUM_MAX;
        end
    end

    assign o_res_valid = r_c_valid;

endmodule

[rtl/ternary_packed_dot_product.sv]
// Ternary packed dot product: one output of a ternary-weight matrix product.
//
// Input queue: drive push with a word of eight Q8.8 activations, eight 2-bit
// weight codes (lane 0 in bits 15:14; 01 = +1, 11 = -1, else 0), a count of
// leading lanes that count, and last. The word is taken at an edge where push
// is high and full is low. Words of one dot product are summed; the word with
// last set ends it and produces one result word, other words produce none.
// Result queue: while empty is low the oldest result is on o_dot_result and
// o_saturated; pop takes it. The result is the sum times gamma, rounded and shifted
// down by GAMMA_FRAC bits and clipped to 32 bits; o_saturated flags the clip.
// Config: i_cfg_we writes gamma (Q4.12) from i_cfg_wdata; write only while idle.
// Path: front stage register, middle queue, back-end sum, multiplier, result queue.
// Throughput: one word per cycle while full is low, bounded by the add-and-clip loop
// of the accumulator in the back end.
// Reset: the sum clears, gamma returns to 1.0, both queues empty.
// When pop stays low the result queue fills, the back end holds the next last
// word, the middle queue fills and full rises.
module ternary_packed_dot_product #(
    parameter int ACT_WIDTH  = 16,
    parameter int GAMMA_FRAC = 12,
    parameter int MID_DEPTH  = 4,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [tpdp_pkg::WCODES_W-1:0]       i_weight_codes,
    input  logic signed [ACT_WIDTH-1:0]         i_act_0,
    input  logic signed [ACT_WIDTH-1:0]         i_act_1,
    input  logic signed [ACT_WIDTH-1:0]         i_act_2,
    input  logic signed [ACT_WIDTH-1:0]         i_act_3,
    input  logic signed [ACT_WIDTH-1:0]         i_act_4,
    input  logic signed [ACT_WIDTH-1:0]         i_act_5,
    input  logic signed [ACT_WIDTH-1:0]         i_act_6,
    input  logic signed [ACT_WIDTH-1:0]         i_act_7,
    input  logic [tpdp_pkg::VL_W-1:0]           i_valid_lanes,
    input  logic                                i_last,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [tpdp_pkg::SUM_W-1:0]   o_dot_result,
    output logic                                o_saturated,
    input  logic                                i_cfg_we,
    input  logic signed [tpdp_pkg::GAMMA_W-1:0] i_cfg_wdata
);

    localparam int LS_W   = ACT_WIDTH + 1 + $clog2(tpdp_pkg::LANES);
    localparam int MID_W  = LS_W + 1;
    localparam int MCNT_W = $clog2(MID_DEPTH + 1);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam int RES_W  = $bits(tpdp_pkg::t_result);

    logic signed [tpdp_pkg::GAMMA_W-1:0] r_gamma;
    logic signed [ACT_WIDTH-1:0]         acts [tpdp_pkg::LANES];
    logic                                accept;
    logic                                f_valid;
    logic signed [LS_W-1:0]              f_lane_sum;
    logic                                f_last;
    logic [MID_W-1:0]                    mid_rdata;
    logic                                mid_empty;
    logic [MCNT_W-1:0]                   mid_count;
    logic [MCNT_W:0]                     mid_used;
    logic                                mid_pop;
    logic [OCNT_W-1:0]                   out_count;
    logic                                res_valid;
    tpdp_pkg::t_result                   res;
    tpdp_pkg::t_result                   out_word;

    // Hold the gamma register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= tpdp_pkg::GAMMA_RESET;
        end else if (i_cfg_we) begin
            r_gamma <= i_cfg_wdata;
        end
    end

    assign acts[0] = i_act_0;
    assign acts[1] = i_act_1;
    assign acts[2] = i_act_2;
    assign acts[3] = i_act_3;
    assign acts[4] = i_act_4;
    assign acts[5] = i_act_5;
    assign acts[6] = i_act_6;
    assign acts[7] = i_act_7;

    // Reserve a middle-queue slot for the word held in the front stage
    assign mid_used = (MCNT_W+1)'(mid_count) + (MCNT_W+1)'(f_valid);
    assign full     = (mid_used >= (MCNT_W+1)'(MID_DEPTH));
    assign accept   = push && !full;

    tpdp_front #(
        .ACT_WIDTH      (ACT_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (accept),
        .i_weight_codes (i_weight_codes),
        .i_acts         (acts),
        .i_valid_lanes  (i_valid_lanes),
        .i_last         (i_last),
        .o_valid        (f_valid),
        .o_lane_sum     (f_lane_sum),
        .o_last         (f_last)
    );

    tpdp_fifo #(
        .WIDTH   (MID_W),
        .DEPTH   (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_wdata ({f_lane_sum, f_last}),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    tpdp_back #(
        .LS_W        (LS_W),
        .GAMMA_FRAC  (GAMMA_FRAC),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (mid_empty),
        .i_lane_sum  (mid_rdata[MID_W-1:1]),
        .i_last      (mid_rdata[0]),
        .i_out_count (out_count),
        .i_gamma     (r_gamma),
        .o_pop       (mid_pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tpdp_fifo #(
        .WIDTH   (RES_W),
        .DEPTH   (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_wdata (res),
        .i_pop   (pop && !empty),
        .o_rdata (out_word),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_dot_result = out_word.dot_result;
    assign o_saturated  = out_word.saturated;

endmodule

[rtl/tpdp_checker.sv]
module tpdp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_full,
    input  logic                              i_empty,
    input  logic                              i_pop,
    input  logic signed [tpdp_pkg::SUM_W-1:0] i_dot_result,
    input  logic                              i_saturated
);

    // Reset leaves both queues empty
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_empty && !i_full))
        else $error("queues not cleared by reset");

    // A clipped result sits exactly at one of the limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_saturated) |->
            (i_dot_result == tpdp_pkg::SUM_MAX || i_dot_result == tpdp_pkg::SUM_MIN))
        else $error("saturated flag without a clipped value");

    // A waiting result stays until it is taken
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> !i_empty)
        else $error("result dropped before pop");

    // A waiting result keeps its value until it is taken
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> ($stable(i_dot_result) && $stable(i_saturated)))
        else $error("result changed while waiting");

endmodule

bind ternary_packed_dot_product tpdp_checker u_tpdp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_full       (full),
    .i_empty      (empty),
    .i_pop        (pop),
    .i_dot_result (o_dot_result),
    .i_saturated  (o_saturated)
);

[test/ternary_packed_dot_product_test.sv]
module ternary_packed_dot_product_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACT_WIDTH    = 16;
    localparam int GAMMA_FRAC   = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_ROW_LEN = 1040;
    localparam logic signed [63:0] ROUND_HALF =
        (GAMMA_FRAC > 0) ? (64'sd1 <<< (GAMMA_FRAC - 1)) : 64'sd0;

    // Code patterns: every lane +1, every lane -1, every lane zero (two encodings), and a mix
    localparam logic [tpdp_pkg::WCODES_W-1:0] CODES_ALL_POS  = 16'h5555;
    localparam logic [tpdp_pkg::WCODES_W-1:0] CODES_ALL_NEG  = 16'hffff;
    localparam logic [tpdp_pkg::WCODES_W-1:0] CODES_ALL_ZERO = 16'h0000;
    localparam logic [tpdp_pkg::WCODES_W-1:0] CODES_ALT_ZERO = 16'haaaa;
    localparam logic [tpdp_pkg::WCODES_W-1:0] CODES_MIXED    = 16'h1be4;

    localparam logic signed [ACT_WIDTH-1:0] ACT_MAX = 16'sh7fff;
    localparam logic signed [ACT_WIDTH-1:0] ACT_MIN = 16'sh8000;

    // One input word as the block sees it; acts[0] is lane 0
    typedef struct packed {
        logic [tpdp_pkg::WCODES_W-1:0]              codes;
        logic [tpdp_pkg::LANES-1:0][ACT_WIDTH-1:0]  acts;
        logic [tpdp_pkg::VL_W-1:0]                  valid_lanes;
        logic                                       last;
    } t_word;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 push = 1'b0;
    logic                                 full;
    logic [tpdp_pkg::WCODES_W-1:0]        i_weight_codes = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_0 = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_1 = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_2 = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_3 = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_4 = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_5 = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_6 = '0;
    logic signed [ACT_WIDTH-1:0]          i_act_7 = '0;
    logic [tpdp_pkg::VL_W-1:0]            i_valid_lanes = '0;
    logic                                 i_last = 1'b0;
    logic                                 empty;
    logic                                 pop = 1'b0;
    logic signed [tpdp_pkg::SUM_W-1:0]    o_dot_result;
    logic                                 o_saturated;
    logic                                 i_cfg_we = 1'b0;
    logic signed [tpdp_pkg::GAMMA_W-1:0]  i_cfg_wdata = '0;

    // Words waiting to be sent, dot products waiting to come out
    t_word             word_backlog[$];
    tpdp_pkg::t_result dot_queue[$];

    // Shadow of the block state
    logic signed [tpdp_pkg::SUM_W-1:0]   running_sum = '0;
    logic signed [tpdp_pkg::GAMMA_W-1:0] gamma_now = tpdp_pkg::GAMMA_RESET;

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int mismatch_count = 0;

    ternary_packed_dot_product #(
        .ACT_WIDTH  (ACT_WIDTH),
        .GAMMA_FRAC (GAMMA_FRAC)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_weight_codes (i_weight_codes),
        .i_act_0        (i_act_0),
        .i_act_1        (i_act_1),
        .i_act_2        (i_act_2),
        .i_act_3        (i_act_3),
        .i_act_4        (i_act_4),
        .i_act_5        (i_act_5),
        .i_act_6        (i_act_6),
        .i_act_7        (i_act_7),
        .i_valid_lanes  (i_valid_lanes),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_dot_result   (o_dot_result),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Fold one accepted word into the shadow sum; queue the dot product on last
    function automatic void accumulate_word(input t_word w);
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        logic signed [63:0] scaled;
        tpdp_pkg::t_result  res;
        int                 n;
        acc = running_sum;
        n = (w.valid_lanes > tpdp_pkg::LANES) ? tpdp_pkg::LANES : int'(w.valid_lanes);
        for (int i = 0; i < n; i++) begin
            case (w.codes[tpdp_pkg::CODE_W*(tpdp_pkg::LANES-1-i) +: tpdp_pkg::CODE_W])
                tpdp_pkg::WCODE_POS: acc = acc + $signed(w.acts[i]);
                tpdp_pkg::WCODE_NEG: acc = acc - $signed(w.acts[i]);
                default: ;
            endcase
        end
        // Clip the running sum silently
        if (acc > tpdp_pkg::SUM_MAX) begin
            acc = tpdp_pkg::SUM_MAX;
        end else if (acc < tpdp_pkg::SUM_MIN) begin
            acc = tpdp_pkg::SUM_MIN;
        end
        running_sum = acc[tpdp_pkg::SUM_W-1:0];
        if (w.last) begin
            prod = 64'(running_sum) * 64'(gamma_now);
            scaled = (prod + ROUND_HALF) >>> GAMMA_FRAC;
            res.saturated = 1'b0;
            if (scaled > tpdp_pkg::SUM_MAX) begin
                scaled = tpdp_pkg::SUM_MAX;
                res.saturated = 1'b1;
            end else if (scaled < tpdp_pkg::SUM_MIN) begin
                scaled = tpdp_pkg::SUM_MIN;
                res.saturated = 1'b1;
            end
            res.dot_result = scaled[tpdp_pkg::SUM_W-1:0];
            dot_queue.push_back(res);
            running_sum = '0;
        end
    endfunction

    function automatic logic [ACT_WIDTH-1:0] random_act();
        case ($urandom_range(9))
            0: return ACT_MAX;
            1: return ACT_MIN;
            2: return '0;
            3: return ACT_WIDTH'($signed($urandom_range(512)) - 256);
            default: return ACT_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [tpdp_pkg::WCODES_W-1:0] random_codes();
        case ($urandom_range(7))
            0: return CODES_ALL_POS;
            1: return CODES_ALL_NEG;
            default: return tpdp_pkg::WCODES_W'($urandom);
        endcase
    endfunction

    function automatic t_word uniform_word(input logic [tpdp_pkg::WCODES_W-1:0] codes,
                                           input logic [ACT_WIDTH-1:0] act,
                                           input int vl, input logic last);
        t_word w;
        w.codes = codes;
        for (int i = 0; i < tpdp_pkg::LANES; i++) w.acts[i] = act;
        w.valid_lanes = tpdp_pkg::VL_W'(vl);
        w.last = last;
        return w;
    endfunction

    function automatic t_word random_word(input int vl, input logic last);
        t_word w;
        w.codes = random_codes();
        for (int i = 0; i < tpdp_pkg::LANES; i++) w.acts[i] = random_act();
        w.valid_lanes = tpdp_pkg::VL_W'(vl);
        w.last = last;
        return w;
    endfunction

    // Queue whole dot products, mostly well formed, some with odd lane counts
    task automatic queue_rows(input int count);
        int sent;
        int len;
        int vl;
        logic last;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
            for (int j = 0; j < len; j++) begin
                last = (j == len - 1);
                vl = last ? $urandom_range(tpdp_pkg::LANES, 1) : tpdp_pkg::LANES;
                if ($urandom_range(6) == 0) vl = $urandom_range(15);
                word_backlog.push_back(random_word(vl, last));
                sent++;
            end
        end
    endtask

    // Queue a row long enough to drive the scaled result into its clip
    task automatic queue_long_row(input logic [tpdp_pkg::WCODES_W-1:0] codes,
                                  input logic [ACT_WIDTH-1:0] act);
        for (int j = 0; j < LONG_ROW_LEN; j++) begin
            word_backlog.push_back(uniform_word(codes, act, tpdp_pkg::LANES, 1'b0));
        end
        // Add three random words, then close the row
        for (int j = 0; j < 3; j++) word_backlog.push_back(random_word(tpdp_pkg::LANES, 1'b0));
        word_backlog.push_back(random_word(tpdp_pkg::LANES, 1'b1));
    endtask

    // Wait until every word is sent and every dot product has come out
    task automatic drain();
        while (word_backlog.size() != 0 || push || dot_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gamma(input logic signed [tpdp_pkg::GAMMA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        gamma_now = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
    endtask

    // Send words from the backlog; hold a word that full turned away
    always @(posedge i_clk) begin : drive_words
        logic  taken;
        t_word w;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            taken = push && !full;
            if (taken) begin
                accumulate_word(word_backlog.pop_front());
            end
            if (push && !taken) begin
                // hold the refused word as it is
            end else if (word_backlog.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                w = word_backlog[0];
                push <= 1'b1;
                i_weight_codes <= w.codes;
                i_act_0 <= w.acts[0];
                i_act_1 <= w.acts[1];
                i_act_2 <= w.acts[2];
                i_act_3 <= w.acts[3];
                i_act_4 <= w.acts[4];
                i_act_5 <= w.acts[5];
                i_act_6 <= w.acts[6];
                i_act_7 <= w.acts[7];
                i_valid_lanes <= w.valid_lanes;
                i_last <= w.last;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Take result words and compare them with the oldest expected one
    always @(posedge i_clk) begin : check_results
        tpdp_pkg::t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (dot_queue.size() == 0) begin
                    $display("%0t: unexpected result word dot_result=%0d saturated=%0b",
                             $time, o_dot_result, o_saturated);
                    mismatch_count++;
                end else begin
                    want = dot_queue.pop_front();
                    if (want.dot_result !== o_dot_result) begin
                        $display("%0t: dot_result expected %0d actual %0d",
                                 $time, want.dot_result, o_dot_result);
                        mismatch_count++;
                    end
                    if (want.saturated !== o_saturated) begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.saturated, o_saturated);
                        mismatch_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial begin : run_phases
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed words at the reset gamma, no idling
        set_idling(0, 0);
        word_backlog.push_back(uniform_word(CODES_ALL_POS, ACT_MAX, tpdp_pkg::LANES, 1'b1));
        word_backlog.push_back(uniform_word(CODES_ALL_NEG, ACT_MIN, tpdp_pkg::LANES, 1'b1));
        word_backlog.push_back(uniform_word(CODES_ALT_ZERO, ACT_MAX, tpdp_pkg::LANES, 1'b1));
        word_backlog.push_back(uniform_word(CODES_ALL_ZERO, ACT_MIN, tpdp_pkg::LANES, 1'b1));
        word_backlog.push_back(uniform_word(CODES_ALL_POS, ACT_MIN, tpdp_pkg::LANES, 1'b0));
        word_backlog.push_back(uniform_word(CODES_ALL_NEG, ACT_MAX, tpdp_pkg::LANES, 1'b1));
        word_backlog.push_back(random_word(tpdp_pkg::LANES, 1'b1));
        word_backlog[$].codes = CODES_MIXED;
        // No lane counts at all
        word_backlog.push_back(uniform_word(CODES_ALL_POS, 16'h0100, 0, 1'b1));
        // Lane counts above eight count every lane
        word_backlog.push_back(uniform_word(CODES_ALL_POS, 16'h0100, 0, 1'b0));
        word_backlog.push_back(uniform_word(CODES_ALL_POS, 16'h0100, 15, 1'b0));
        word_backlog.push_back(uniform_word(CODES_ALL_NEG, 16'h0001, 9, 1'b1));
        // Short counts ahead of the last word
        word_backlog.push_back(uniform_word(CODES_ALL_POS, 16'h0200, 3, 1'b0));
        word_backlog.push_back(random_word(5, 1'b0));
        word_backlog.push_back(uniform_word(CODES_ALL_POS, 16'h0040, 1, 1'b1));
        // One lane weighted at a time
        for (int lane = 0; lane < tpdp_pkg::LANES; lane++) begin
            word_backlog.push_back(random_word(tpdp_pkg::LANES, lane[0]));
            word_backlog[$].codes = tpdp_pkg::WCODES_W'(tpdp_pkg::WCODE_POS)
                                    << (tpdp_pkg::CODE_W * (tpdp_pkg::LANES - 1 - lane));
        end
        drain();

        // Largest gamma, scaled result clipped
        write_gamma(16'sh7fff);
        queue_long_row(CODES_ALL_POS, ACT_MAX);
        queue_rows(40);
        drain();

        write_gamma(16'sh8000);
        queue_rows(40);
        drain();

        write_gamma(tpdp_pkg::GAMMA_W'($urandom));
        set_idling(86, 0);
        queue_rows(150);
        drain();

        write_gamma(16'sd1);
        set_idling(0, 86);
        queue_rows(150);
        drain();

        write_gamma(-16'sd1);
        set_idling(37, 37);
        queue_rows(150);
        drain();

        write_gamma(16'sd0);
        set_idling(0, 0);
        queue_rows(50);
        drain();

        write_gamma(tpdp_pkg::GAMMA_RESET);
        set_idling(37, 37);
        queue_rows(100);
        drain();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
